// File: sv/utf8r_pkg.sv
// ----------------------------------------------------------------------------
// utf8r_pkg
// Types, constants and lead-byte decode shared by the UTF-8 stream repair
// logic.
// ----------------------------------------------------------------------------
package utf8r_pkg;

  localparam int unsigned BufDepth = 6;
  localparam int unsigned CntW     = $clog2(BufDepth + 1);

  // U+FFFD encoded in UTF-8.
  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  localparam logic [7:0] ContLo   = 8'h80;
  localparam logic [7:0] ContHi   = 8'hBF;
  localparam logic [7:0] Lead2Lo  = 8'hC2;
  localparam logic [7:0] Lead2Hi  = 8'hDF;
  localparam logic [7:0] Lead3Lo  = 8'hE0;
  localparam logic [7:0] Lead3Hi  = 8'hEF;
  localparam logic [7:0] Lead4Lo  = 8'hF0;
  localparam logic [7:0] Lead4Hi  = 8'hF4;
  localparam logic [7:0] LeadE0   = 8'hE0;
  localparam logic [7:0] LeadED   = 8'hED;
  localparam logic [7:0] LeadF0   = 8'hF0;
  localparam logic [7:0] LeadF4   = 8'hF4;
  localparam logic [7:0] E0SecLo  = 8'hA0;
  localparam logic [7:0] EDSecHi  = 8'h9F;
  localparam logic [7:0] F0SecLo  = 8'h90;
  localparam logic [7:0] F4SecHi  = 8'h8F;

  // Sequence lengths; zero marks a byte that cannot start a sequence.
  localparam logic [2:0] LenBad = 3'd0;
  localparam logic [2:0] Len1   = 3'd1;
  localparam logic [2:0] Len2   = 3'd2;
  localparam logic [2:0] Len3   = 3'd3;
  localparam logic [2:0] Len4   = 3'd4;

  typedef struct packed {
    logic       rep;
    logic [7:0] data;
  } res_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LenBad;
    if (b < ContLo) begin
      len = Len1;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      len = Len2;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      len = Len3;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      len = Len4;
    end
    return len;
  endfunction

  // Range check of the byte right after a lead, with the narrowed ranges
  // for the overlong, surrogate and above-U+10FFFF cases.
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ContLo;
    hi = ContHi;
    if (lead == LeadE0) begin
      lo = E0SecLo;
    end
    if (lead == LeadED) begin
      hi = EDSecHi;
    end
    if (lead == LeadF0) begin
      lo = F0SecLo;
    end
    if (lead == LeadF4) begin
      hi = F4SecHi;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

// File: sv/utf8_stream_repair_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_repair_unit
// Byte-serial UTF-8 checker that passes well-formed sequences through and
// replaces each maximal ill-formed subpart with U+FFFD.
// ----------------------------------------------------------------------------
// Each input beat is decoded combinationally against the held partial
// sequence, and the result bytes it produces (zero to six) are loaded into a
// six-entry output buffer that drains one byte per cycle while out_tready is
// high. Well-formed single-byte text runs at one byte per cycle, each byte
// appearing on the output in the cycle after it is taken; a multi-byte
// sequence is held until its last byte arrives and then leaves as a burst.
// A new beat is taken whenever the output buffer is empty or its final byte
// is being taken in the same cycle, so one beat's results all leave before
// the next beat's. out_tlast marks the last byte caused by one input beat.
module utf8_stream_repair_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] is_replacement
  output logic       out_tlast   // run_last
);

  utf8r_pkg::res_t             buf_r   [utf8r_pkg::BufDepth];
  utf8r_pkg::res_t             buf_nxt [utf8r_pkg::BufDepth];
  logic [utf8r_pkg::CntW-1:0]  buf_cnt_r, buf_cnt_nxt;

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;

  utf8r_pkg::res_t             res     [utf8r_pkg::BufDepth];
  logic [utf8r_pkg::CntW-1:0]  res_cnt;

  logic in_acc;
  logic out_acc;
  logic cont_ok;
  logic start_b;
  logic [2:0] b_len;

  assign out_tvalid = (buf_cnt_r != '0);
  assign out_tdata  = buf_r[0].data;
  assign out_tuser  = buf_r[0].rep;
  assign out_tlast  = (buf_cnt_r == utf8r_pkg::CntW'(1));
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = (buf_cnt_r == '0) || (out_tlast && out_tready);
  assign in_acc     = in_tvalid && in_tready;

  assign b_len   = utf8r_pkg::lead_len(in_tdata);
  assign cont_ok = (held_cnt_r == 2'd1) ? utf8r_pkg::second_ok(held_r[0], in_tdata)
                 : (in_tdata >= utf8r_pkg::ContLo && in_tdata <= utf8r_pkg::ContHi);

  // Decode of one input beat into its result bytes and the next held state.
  always_comb begin
    for (int i = 0; i < utf8r_pkg::BufDepth; i++) begin
      res[i] = '{rep: 1'b0, data: 8'h00};
    end
    res_cnt      = '0;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    exp_len_nxt  = exp_len_r;
    start_b      = 1'b0;

    if (held_cnt_r == 2'd0) begin
      start_b = 1'b1;
    end else if (cont_ok) begin
      if ({1'b0, held_cnt_r} + 3'd1 == exp_len_r) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_cnt_r) begin
            res[res_cnt] = '{rep: 1'b0, data: held_r[i]};
            res_cnt      = res_cnt + 1'b1;
          end
        end
        res[res_cnt] = '{rep: 1'b0, data: in_tdata};
        res_cnt      = res_cnt + 1'b1;
        held_cnt_nxt = 2'd0;
        exp_len_nxt  = 3'd0;
      end else begin
        held_nxt[held_cnt_r] = in_tdata;
        held_cnt_nxt         = held_cnt_r + 2'd1;
      end
    end else begin
      // The breaking byte closes the held subpart and is retried as a lead.
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte0};
      res_cnt      = res_cnt + 1'b1;
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte1};
      res_cnt      = res_cnt + 1'b1;
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte2};
      res_cnt      = res_cnt + 1'b1;
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
      start_b      = 1'b1;
    end

    if (start_b) begin
      case (b_len)
        utf8r_pkg::Len1: begin
          res[res_cnt] = '{rep: 1'b0, data: in_tdata};
          res_cnt      = res_cnt + 1'b1;
        end
        utf8r_pkg::Len2, utf8r_pkg::Len3, utf8r_pkg::Len4: begin
          held_nxt[0]  = in_tdata;
          held_cnt_nxt = 2'd1;
          exp_len_nxt  = b_len;
        end
        default: begin
          res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte0};
          res_cnt      = res_cnt + 1'b1;
          res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte1};
          res_cnt      = res_cnt + 1'b1;
          res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte2};
          res_cnt      = res_cnt + 1'b1;
        end
      endcase
    end

    // A stream that ends inside a sequence closes it with one replacement.
    if (in_tlast && held_cnt_nxt != 2'd0) begin
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte0};
      res_cnt      = res_cnt + 1'b1;
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte1};
      res_cnt      = res_cnt + 1'b1;
      res[res_cnt] = '{rep: 1'b1, data: utf8r_pkg::RepByte2};
      res_cnt      = res_cnt + 1'b1;
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end
  end

  // Output buffer: shifts down on each taken beat, reloads on a new input.
  always_comb begin
    buf_nxt     = buf_r;
    buf_cnt_nxt = buf_cnt_r;
    if (out_acc) begin
      for (int i = 0; i < utf8r_pkg::BufDepth - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      buf_cnt_nxt = buf_cnt_r - 1'b1;
    end
    if (in_acc) begin
      buf_nxt     = res;
      buf_cnt_nxt = res_cnt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (in_acc) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r  <= '0;
      held_cnt_r <= 2'd0;
      exp_len_r  <= 3'd0;
    end else begin
      buf_cnt_r <= buf_cnt_nxt;
      if (in_acc) begin
        held_cnt_r <= held_cnt_nxt;
        exp_len_r  <= exp_len_nxt;
      end
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= utf8r_pkg::CntW'(utf8r_pkg::BufDepth))
    else $error("output buffer count exceeds its depth");

  a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |-> ({1'b0, held_cnt_r} < exp_len_r) &&
                           (exp_len_r >= utf8r_pkg::Len2) &&
                           (exp_len_r <= utf8r_pkg::Len4))
    else $error("held sequence length inconsistent with expected length");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> held_cnt_r == 2'd0)
    else $error("partial sequence held past end of stream");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (buf_cnt_r == '0) || (out_acc && out_tlast))
    else $error("input taken while undelivered results remain");

endmodule

// File: bench/utf8_stream_repair_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_repair_unit_tb
// Self-checking bench for the UTF-8 stream repair unit. A directed byte run
// covers the lead and continuation boundaries, the narrowed second-byte
// ranges, broken sequences and streams that end inside a sequence. It is
// followed by random text built mostly from well-formed characters, mixed
// with cut-off sequences, corrupted sequences and raw noise bytes. Both
// stream sides idle at random, and the output side holds off once for a long
// stretch. Every output beat is checked against a scoreboard that tracks the
// held partial sequence and predicts each repaired byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_stream_repair_unit_tb;

  localparam int RandomBytes   = 100;
  localparam int CycleLimit    = 50000;
  localparam int DrainCycles   = 16;
  localparam int HoldOffCycles = 80;
  localparam int HoldOffAfter  = 40;

  // Bit 8 marks the final byte of a stream.
  localparam logic [8:0] DirectedBeats [25] = '{
    9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0F5, 9'h0FF,
    9'h0C2, 9'h080, 9'h0E0, 9'h0A0, 9'h080, 9'h0ED, 9'h09F, 9'h0BF,
    9'h0E0, 9'h09F, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
    9'h0E2, 9'h182, 9'h0F0, 9'h090, 9'h1C2
  };

  typedef struct {
    logic [7:0] data;
    logic       rep;
    logic       last;
  } repaired_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } text_beat_t;

  class utf8_repair_scoreboard;
    repaired_byte_t expected_q[$];
    logic [7:0]     held[3];
    int             held_cnt;
    logic [2:0]     seq_len;
    int             errors;
    int             bytes_in;
    int             bytes_out;
    int             fffd_count;

    function new();
      held_cnt   = 0;
      seq_len    = utf8r_pkg::LenBad;
      errors     = 0;
      bytes_in   = 0;
      bytes_out  = 0;
      fffd_count = 0;
    endfunction

    // Sequence length for a lead byte and the legal range of the byte after it.
    function logic [2:0] decode_lead(input logic [7:0] b, output logic [7:0] lo,
                                     output logic [7:0] hi);
      lo = utf8r_pkg::ContLo;
      hi = utf8r_pkg::ContHi;
      if (b <= 8'h7F) begin
        return utf8r_pkg::Len1;
      end
      if (b >= utf8r_pkg::Lead2Lo && b <= utf8r_pkg::Lead2Hi) begin
        return utf8r_pkg::Len2;
      end
      if (b >= utf8r_pkg::Lead3Lo && b <= utf8r_pkg::Lead3Hi) begin
        if (b == utf8r_pkg::LeadE0) lo = utf8r_pkg::E0SecLo;
        if (b == utf8r_pkg::LeadED) hi = utf8r_pkg::EDSecHi;
        return utf8r_pkg::Len3;
      end
      if (b >= utf8r_pkg::Lead4Lo && b <= utf8r_pkg::Lead4Hi) begin
        if (b == utf8r_pkg::LeadF0) lo = utf8r_pkg::F0SecLo;
        if (b == utf8r_pkg::LeadF4) hi = utf8r_pkg::F4SecHi;
        return utf8r_pkg::Len4;
      end
      return utf8r_pkg::LenBad;
    endfunction

    function void push(input logic [7:0] b, input logic rep);
      repaired_byte_t r;
      r.data = b;
      r.rep  = rep;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void push_fffd();
      push(utf8r_pkg::RepByte0, 1'b1);
      push(utf8r_pkg::RepByte1, 1'b1);
      push(utf8r_pkg::RepByte2, 1'b1);
      fffd_count++;
    endfunction

    function void drop_held();
      held_cnt = 0;
      seq_len  = utf8r_pkg::LenBad;
    endfunction

    function void open_sequence(input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [2:0] len;
      len = decode_lead(b, lo, hi);
      if (len == utf8r_pkg::Len1) begin
        push(b, 1'b0);
      end else if (len == utf8r_pkg::LenBad) begin
        push_fffd();
      end else begin
        held[0]  = b;
        held_cnt = 1;
        seq_len  = len;
      end
    endfunction

    function void note_input(input logic [7:0] b, input logic eos);
      logic [7:0] lo;
      logic [7:0] hi;
      int         q_mark;
      int         i;
      q_mark = expected_q.size();
      bytes_in++;
      if (held_cnt == 0) begin
        open_sequence(b);
      end else begin
        void'(decode_lead(held[0], lo, hi));
        // Only the byte right after the lead has a narrowed range.
        if (held_cnt > 1) begin
          lo = utf8r_pkg::ContLo;
          hi = utf8r_pkg::ContHi;
        end
        if (b >= lo && b <= hi) begin
          if (held_cnt + 1 == int'(seq_len)) begin
            for (i = 0; i < held_cnt; i++) push(held[i], 1'b0);
            push(b, 1'b0);
            drop_held();
          end else begin
            held[held_cnt] = b;
            held_cnt++;
          end
        end else begin
          push_fffd();
          drop_held();
          open_sequence(b);
        end
      end
      if (eos && held_cnt != 0) begin
        push_fffd();
        drop_held();
      end
      if (expected_q.size() > q_mark) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void report(input string what);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(input logic [7:0] data, input logic rep, input logic last);
      repaired_byte_t want;
      bytes_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat data=%02h rep=%0b last=%0b", data, rep, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data || rep !== want.rep || last !== want.last) begin
        report($sformatf({"beat %0d expected data=%02h rep=%0b last=%0b, ",
                          "got data=%02h rep=%0b last=%0b"},
                         bytes_out, want.data, want.rep, want.last, data, rep, last));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  utf8_repair_scoreboard sb;
  text_beat_t            stim_q[$];
  int                    cycle_count;
  int                    longest_hold;
  logic                  steady_tx;
  logic                  steady_rx;

  utf8_stream_repair_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Random text: mostly well-formed characters, some cut short or corrupted,
  // some raw noise. Any byte may close the stream.
  function automatic void build_random_text(input int count);
    logic [7:0] seq[$];
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    text_beat_t tb;
    int         kind;
    int         len;
    int         goal;
    goal = stim_q.size() + count;
    while (stim_q.size() < goal) begin
      seq  = {};
      kind = $urandom_range(0, 15);
      if (kind < 4) begin
        seq.push_back(8'($urandom_range(0, 127)));
      end else if (kind >= 13) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = (kind < 6) ? 2 : (kind < 9) ? 3 : (kind < 11) ? 4 : $urandom_range(2, 4);
        case (len)
          2: lead = 8'($urandom_range(utf8r_pkg::Lead2Lo, utf8r_pkg::Lead2Hi));
          3: lead = 8'($urandom_range(utf8r_pkg::Lead3Lo, utf8r_pkg::Lead3Hi));
          default: lead = 8'($urandom_range(utf8r_pkg::Lead4Lo, utf8r_pkg::Lead4Hi));
        endcase
        void'(sb.decode_lead(lead, lo, hi));
        seq.push_back(lead);
        seq.push_back(8'($urandom_range(lo, hi)));
        while (seq.size() < len) begin
          seq.push_back(8'($urandom_range(utf8r_pkg::ContLo, utf8r_pkg::ContHi)));
        end
        if (kind == 11) begin
          repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
        end else if (kind == 12) begin
          seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end
      end
      foreach (seq[i]) begin
        tb.data = seq[i];
        tb.eos  = ($urandom_range(0, 15) == 0);
        stim_q.push_back(tb);
      end
    end
  endfunction

  function automatic int draw_idle(input logic steady);
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(input text_beat_t tb);
    int gap;
    if ($urandom_range(0, 15) == 0) steady_tx = ~steady_tx;
    gap = draw_idle(steady_tx);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tb.data;
    in_tlast  <= tb.eos;
    do @(posedge clk); while (!in_tready);
    sb.note_input(tb.data, tb.eos);
    @(negedge clk);
  endtask

  // Output side: random stalls, and one long hold-off that backs up the block.
  initial begin
    int  gap;
    bit  held_off;
    out_tready   = 1'b0;
    steady_rx    = 1'b0;
    held_off     = 1'b0;
    longest_hold = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady_rx = ~steady_rx;
      gap = draw_idle(steady_rx);
      if (!held_off && sb.bytes_out >= HoldOffAfter) begin
        gap      = HoldOffCycles;
        held_off = 1'b1;
      end
      if (gap > longest_hold) longest_hold = gap;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata, out_tuser, out_tlast);
      @(negedge clk);
    end
  end

  initial begin
    text_beat_t tb;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    steady_tx = 1'b0;
    sb        = new();
    foreach (DirectedBeats[i]) begin
      tb.data = DirectedBeats[i][7:0];
      tb.eos  = DirectedBeats[i][8];
      stim_q.push_back(tb);
    end
    build_random_text(RandomBytes);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) send_beat(stim_q[i]);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d input bytes, checked %0d output bytes holding %0d U+FFFD substitutes.",
             sb.bytes_in, sb.bytes_out, sb.fffd_count);
    $display("Longest output hold-off was %0d cycles; %0d mismatches in %0d cycles.",
             longest_hold, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
